FILE: sv/steering_pi_speed_controller_defines.svh
// assertion macros for the steering pi speed controller
`ifndef STEERING_PI_SPEED_CONTROLLER_DEFINES_SVH
`define STEERING_PI_SPEED_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

`define STC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define STC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define STC_ASSERT_IMPL(label, ante, cons)

`define STC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: sv/stc_pkg.sv
// shared types, widths and register codes of the steering pi speed controller
package stc_pkg;

    localparam int ADC_BITS   = 12;
    localparam int ANGLE_W    = 16;
    localparam int ERR_W      = 17;
    localparam int GAIN_W     = 24;
    localparam int KSUM_W     = 25;
    localparam int LIMIT_W    = 16;
    localparam int TLIM_W     = 15;
    localparam int RANGE_W    = 16;
    localparam int DBAND_W    = 15;
    localparam int RPM_W      = 17;
    localparam int ACC_W      = 33;
    localparam int ACC_FRAC   = 16;
    localparam int PROD_SHIFT = 8;
    localparam int MUL_A_W    = 26;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int DELTA_W    = PROD_W + 1;
    localparam int STEP_W     = DELTA_W - PROD_SHIFT;
    localparam int SUM_W      = STEP_W + 1;

    localparam int S_TDATA_W  = ((ADC_BITS + ANGLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((RPM_W + ANGLE_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_DT_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SENSE_RANGE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT       = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_MEAS,
        ST_ERR,
        ST_MUL_SUM,
        ST_MUL_KP,
        ST_DELTA,
        ST_ACC,
        ST_SAT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_MAP,
        MUL_KSUM,
        MUL_KP
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     meas_en;
        logic     err_en;
        logic     delta_en;
        logic     acc_en;
        logic     sat_en;
        logic     out_en;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

FILE: sv/stc_ctrl.sv
// control sequencer stepping one tick through the shared datapath
module stc_ctrl
    import stc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // no beat is taken while reset is held
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MAP;
                end
            end
            ST_MAP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_MAP;
                n_state       = ST_MEAS;
            end
            ST_MEAS: begin
                o_cmd.meas_en = 1'b1;
                n_state       = ST_ERR;
            end
            ST_ERR: begin
                o_cmd.err_en = 1'b1;
                n_state      = ST_MUL_SUM;
            end
            ST_MUL_SUM: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_KSUM;
                n_state       = ST_MUL_KP;
            end
            ST_MUL_KP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_KP;
                n_state       = ST_DELTA;
            end
            ST_DELTA: begin
                o_cmd.delta_en = 1'b1;
                n_state        = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = ST_SAT;
            end
            ST_SAT: begin
                o_cmd.sat_en = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_en = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/stc_datapath.sv
// config registers, shared multiplier, pi state and output register
module stc_datapath
    import stc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata
);

    logic [GAIN_W-1:0]  r_kp;
    logic [GAIN_W-1:0]  r_ki;
    logic [LIMIT_W-1:0] r_rpm_limit;
    logic [TLIM_W-1:0]  r_target_limit;
    logic [RANGE_W-1:0] r_sense_range;
    logic [DBAND_W-1:0] r_deadband;
    logic               r_invert;

    logic [ADC_BITS-1:0]       r_adc;
    logic signed [ANGLE_W-1:0] r_target;
    logic [KSUM_W-1:0]         r_ksum;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_prod_kp;
    logic signed [ANGLE_W-1:0] r_meas;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ERR_W-1:0]   r_prev;
    logic signed [DELTA_W-1:0] r_delta;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_out_valid;
    logic signed [RPM_W-1:0]   r_rpm;
    logic signed [ANGLE_W-1:0] r_meas_out;

    logic signed [ANGLE_W-1:0] w_target_in;
    logic signed [ANGLE_W-1:0] w_lim;
    logic signed [ANGLE_W-1:0] w_target_clamped;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_mul_p;
    logic [ANGLE_W-1:0]        w_scaled;
    logic signed [ANGLE_W:0]   w_meas_wide;
    logic signed [ERR_W-1:0]   w_err;
    logic [ERR_W-1:0]          w_mag;
    logic signed [STEP_W-1:0]  w_step;
    logic signed [SUM_W-1:0]   w_cap;
    logic signed [ACC_W-1:0]   w_acc_sat;
    logic signed [ACC_W-1:0]   w_acc_bias;
    logic signed [RPM_W-1:0]   w_rpm_trunc;
    logic signed [RPM_W-1:0]   w_rpm;
    logic                      w_out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp           <= GAIN_W'(65536);
            r_ki           <= '0;
            r_rpm_limit    <= LIMIT_W'(10000);
            r_target_limit <= TLIM_W'(7680);
            r_sense_range  <= RANGE_W'(23040);
            r_deadband     <= DBAND_W'(256);
            r_invert       <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KP_GAIN:      r_kp           <= i_cfg_data[GAIN_W-1:0];
                REG_KI_DT_GAIN:   r_ki           <= i_cfg_data[GAIN_W-1:0];
                REG_RPM_LIMIT:    r_rpm_limit    <= i_cfg_data[LIMIT_W-1:0];
                REG_TARGET_LIMIT: r_target_limit <= i_cfg_data[TLIM_W-1:0];
                REG_SENSE_RANGE:  r_sense_range  <= i_cfg_data[RANGE_W-1:0];
                REG_DEADBAND:     r_deadband     <= i_cfg_data[DBAND_W-1:0];
                REG_INVERT:       r_invert       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // target clamp at input capture
    always_comb begin
        w_target_in = $signed(i_s_tdata[ADC_BITS +: ANGLE_W]);
        w_lim       = $signed({1'b0, r_target_limit});
        if (w_target_in > w_lim) begin
            w_target_clamped = w_lim;
        end else if (w_target_in < -w_lim) begin
            w_target_clamped = -w_lim;
        end else begin
            w_target_clamped = w_target_in;
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_MAP: begin
                w_mul_a = $signed(MUL_A_W'(r_sense_range));
                w_mul_b = $signed(MUL_B_W'(r_adc));
            end
            MUL_KSUM: begin
                w_mul_a = $signed(MUL_A_W'(r_ksum));
                w_mul_b = MUL_B_W'(r_err);
            end
            MUL_KP: begin
                w_mul_a = $signed(MUL_A_W'(r_kp));
                w_mul_b = MUL_B_W'(r_prev);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // angle mapping and deadband
    assign w_scaled    = r_prod[ADC_BITS +: ANGLE_W];
    assign w_meas_wide = $signed({1'b0, w_scaled})
                       - $signed({2'b00, r_sense_range[RANGE_W-1:1]});
    assign w_err       = ERR_W'(r_target) - ERR_W'(r_meas);
    assign w_mag       = w_err[ERR_W-1] ? ERR_W'(-w_err) : ERR_W'(w_err);

    // accumulator update and saturation
    assign w_step = r_delta[DELTA_W-1:PROD_SHIFT];
    assign w_cap  = $signed(SUM_W'({r_rpm_limit, {ACC_FRAC{1'b0}}}));

    always_comb begin
        if (r_sum > w_cap) begin
            w_acc_sat = w_cap[ACC_W-1:0];
        end else if (r_sum < -w_cap) begin
            w_acc_sat = ACC_W'(-w_cap);
        end else begin
            w_acc_sat = r_sum[ACC_W-1:0];
        end
    end

    // truncate toward zero, then optional negation
    assign w_acc_bias  = r_acc[ACC_W-1] ? (r_acc + ACC_W'((1 << ACC_FRAC) - 1)) : r_acc;
    assign w_rpm_trunc = w_acc_bias[ACC_W-1:ACC_FRAC];
    assign w_rpm       = r_invert ? -w_rpm_trunc : w_rpm_trunc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_adc    <= i_s_tdata[ADC_BITS-1:0];
            r_target <= w_target_clamped;
            r_ksum   <= KSUM_W'(r_kp) + KSUM_W'(r_ki);
        end
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_sel == MUL_KP) begin
                r_prod_kp <= w_mul_p;
            end else begin
                r_prod <= w_mul_p;
            end
        end
        if (i_cmd.meas_en) begin
            r_meas <= w_meas_wide[ANGLE_W-1:0];
        end
        if (i_cmd.delta_en) begin
            r_delta <= DELTA_W'(r_prod) - DELTA_W'(r_prod_kp);
        end
        if (i_cmd.acc_en) begin
            r_sum <= SUM_W'(r_acc) + SUM_W'(w_step);
        end
        if (i_cmd.out_en) begin
            r_rpm      <= w_rpm;
            r_meas_out <= r_meas;
        end
    end

    // pi state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err  <= '0;
            r_prev <= '0;
            r_acc  <= '0;
        end else begin
            if (i_cmd.err_en) begin
                r_err <= (w_mag < ERR_W'(r_deadband)) ? '0 : w_err;
            end
            if (i_cmd.delta_en) begin
                r_prev <= r_err;
            end
            if (i_cmd.sat_en) begin
                r_acc <= w_acc_sat;
            end
        end
    end

    // output register
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_en) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = w_out_free;
    assign o_m_tvalid     = r_out_valid;
    assign o_m_tdata      = {{(M_TDATA_W - RPM_W - ANGLE_W){1'b0}}, r_meas_out, r_rpm};

endmodule

FILE: sv/steering_pi_speed_controller.sv
// top level of the steering pi speed controller
//
//   channel   direction  beat contents
//   s_axis    in         one control tick: sample and target angle
//   m_axis    out        one result per tick: rpm command and measured angle
//   cfg       in         register index and write data, ready out of reset
//
// a tick steps through the states map, meas, err, mul_sum, mul_kp, delta, acc,
// sat and out before the next beat is accepted; the sequencer steps three
// products through one shared 26 x 18 multiplier
// reset sets the registers to their defaults and clears error and accumulator
// a finished result waits in the output register; the next beat is taken
// meanwhile, and the sequencer only holds in its last step while it is full
`include "steering_pi_speed_controller_defines.svh"

module steering_pi_speed_controller
    import stc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // adc_sample [11:0], target_angle [27:12], zero fill
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // rpm_command [16:0], measured_angle [32:17], zero fill
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = i_rst_n;

    stc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    stc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    `STC_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready)
    `STC_ASSERT_IMPL(a_no_result_overwrite, w_cmd.out_en, w_sts.out_free)
    `STC_ASSERT_IMPL(a_result_from_sequencer, $rose(o_m_tvalid), $past(w_cmd.out_en))

endmodule
